// ===== rtl/sorted_static_linked_list_macros.svh =====
// Assertion macros used by the sorted linked list sequencer.
`ifndef SORTED_STATIC_LINKED_LIST_MACROS_SVH
`define SORTED_STATIC_LINKED_LIST_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SSLL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted list assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SSLL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted list assertion failed");

`endif

// ===== rtl/ssll_pkg.sv =====
// Package with the types, constants and helpers of the sorted linked list.
`default_nettype none
package ssll_pkg;

	// Node store geometry; a link one bit wider than a node index holds null.
	localparam int CAPACITY = 64;
	localparam int NODE_W   = $clog2(CAPACITY);
	localparam int LINK_W   = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int IDX_W    = 6;

	localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

	typedef logic [NODE_W-1:0]       node_t;
	typedef logic [LINK_W-1:0]       link_t;
	typedef logic signed [KEY_W-1:0] key_t;

	typedef enum logic [1:0] {
		OP_SEARCH = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		RES_DONE    = 2'd0,
		RES_ABSENT  = 2'd1,
		RES_PRESENT = 2'd2,
		RES_NOFREE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_DECIDE,
		S_INS_A,
		S_INS_B,
		S_DEL_B,
		S_DONE
	} state_t;

	// Access request from the sequencer to the node store.
	typedef struct packed {
		logic  rd_en;
		node_t rd_addr;
		logic  key_we;
		logic  link_we;
		node_t wr_addr;
		key_t  wr_key;
		link_t wr_link;
	} store_req_t;

	// Link value of a node before it is first written: the next node, last one null.
	function automatic link_t link_init(input node_t addr);
		link_t r;
		if (addr == NODE_W'(CAPACITY - 1))
			r = NIL;
		else
			r = LINK_W'(addr) + LINK_W'(1);
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ssll_if.sv =====
// Request and response channel interfaces of the sorted linked list.
`default_nettype none
interface ssll_req_if;
	logic                  valid;
	logic                  ready;
	logic [1:0]            opcode;
	logic signed [31:0]    key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink (input valid, input opcode, input key, output ready);
endinterface

interface ssll_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [5:0] node_index;

	modport source (output valid, output status, output node_index, input ready);
	modport sink (input valid, input status, input node_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/sorted_static_linked_list.sv =====
// Top level of the sorted linked list: sequencer, node store and response register.
// Keeps up to 64 distinct signed 32-bit keys in ascending order as a linked list in a
// node store, with unused nodes on a free chain. Each request (search, insert, delete)
// walks the list from its head at one node per cycle, set by the single read port of
// the node store, until it reaches a key not less than the one asked. A request visits at
// most 64 nodes, and at most 63 for an insert that takes a node; a request with an unused
// opcode goes straight to the done state with no walk. No new request is accepted until
// the response is registered, and the next one can be taken in the cycle after, so a
// request occupies the block until its response finds room in the output register.
// The response waits in an output register and the block takes the next request while it
// waits. No clearing pass is needed after reset.
`default_nettype none
module sorted_static_linked_list (
	input  wire         clk,
	input  wire         arst_n,
	ssll_req_if.sink    req,
	ssll_rsp_if.source  rsp
);
	import ssll_pkg::*;

	store_req_t mem_req;
	key_t       rd_key;
	link_t      rd_link;
	logic       res_valid;
	status_t    res_status;
	node_t      res_idx;
	logic       out_free;
	logic       rsp_valid_q;
	logic [1:0] rsp_status_q;
	logic [5:0] rsp_idx_q;

	assign out_free = !rsp_valid_q || rsp.ready;

	ssll_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_key    (req.key),
		.req_ready  (req.ready),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res_status (res_status),
		.res_idx    (res_idx),
		.mem_req    (mem_req),
		.rd_key     (rd_key),
		.rd_link    (rd_link)
	);

	ssll_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_key  (rd_key),
		.rd_link (rd_link)
	);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (res_valid)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_status_q <= res_status;
			rsp_idx_q    <= IDX_W'(res_idx);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.node_index = rsp_idx_q;

endmodule
`default_nettype wire

// ===== rtl/ssll_store.sv =====
// Node store: key memory and link memory with one read and one write port each.
`default_nettype none
module ssll_store (
	input  wire                     clk,
	input  wire                     arst_n,
	input  ssll_pkg::store_req_t    req,
	output ssll_pkg::key_t          rd_key,
	output ssll_pkg::link_t         rd_link
);
	import ssll_pkg::*;

	key_t                  key_mem [CAPACITY];
	link_t                 link_mem [CAPACITY];
	logic [CAPACITY-1:0]   link_vld_q;
	key_t                  rd_key_q;
	link_t                 rd_link_q;
	node_t                 rd_addr_q;
	logic                  rd_vld_q;

	// Memory writes and registered reads.
	always_ff @(posedge clk) begin
		if (req.key_we)
			key_mem[req.wr_addr] <= req.wr_key;
		if (req.link_we)
			link_mem[req.wr_addr] <= req.wr_link;
		if (req.rd_en) begin
			rd_key_q  <= key_mem[req.rd_addr];
			rd_link_q <= link_mem[req.rd_addr];
			rd_addr_q <= req.rd_addr;
		end
	end

	// Per-entry valid bits stand in for the reset pattern of the link memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (req.link_we)
				link_vld_q[req.wr_addr] <= 1'b1;
			if (req.rd_en)
				rd_vld_q <= link_vld_q[req.rd_addr];
		end
	end

	assign rd_key  = rd_key_q;
	assign rd_link = rd_vld_q ? rd_link_q : link_init(rd_addr_q);

endmodule
`default_nettype wire

// ===== rtl/ssll_seq.sv =====
// Sequencer that walks the list with shared key comparators and relinks nodes.
`default_nettype none
`include "sorted_static_linked_list_macros.svh"
module ssll_seq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     req_valid,
	input  wire [1:0]               req_opcode,
	input  ssll_pkg::key_t          req_key,
	output logic                    req_ready,
	input  wire                     out_free,
	output logic                    res_valid,
	output ssll_pkg::status_t       res_status,
	output ssll_pkg::node_t         res_idx,
	output ssll_pkg::store_req_t    mem_req,
	input  ssll_pkg::key_t          rd_key,
	input  ssll_pkg::link_t         rd_link
);
	import ssll_pkg::*;

	state_t  state_q, state_d;
	opcode_t op_q;
	key_t    key_q;
	link_t   pos_q;
	link_t   prev_q;
	link_t   nxt_q;
	logic    found_q;
	link_t   list_head_q;
	link_t   free_head_q;
	status_t status_q;
	node_t   idx_q;
	logic    accept;
	logic    key_ge;
	logic    key_eq;
	logic    op_ok;

	assign accept = req_valid && req_ready;
	assign op_ok  = (req_opcode == OP_SEARCH) || (req_opcode == OP_INSERT) ||
		(req_opcode == OP_DELETE);

	// The key comparators, shared by every step of the walk.
	assign key_ge = rd_key >= key_q;
	assign key_eq = rd_key == key_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!op_ok)
						state_d = S_DONE;
					else if (list_head_q == NIL)
						state_d = S_DECIDE;
					else
						state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (key_ge || rd_link == NIL)
					state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = S_DONE;
				if (op_q == OP_INSERT && !found_q && free_head_q != NIL)
					state_d = S_INS_A;
				else if (op_q == OP_DELETE && found_q)
					state_d = S_DEL_B;
			end
			S_INS_A: state_d = (prev_q == NIL) ? S_DONE : S_INS_B;
			S_INS_B: state_d = S_DONE;
			S_DEL_B: state_d = S_DONE;
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs: handshake and node store accesses.
	always_comb begin
		req_ready = 1'b0;
		res_valid = 1'b0;
		mem_req   = '0;
		unique case (state_q)
			S_IDLE: begin
				req_ready       = 1'b1;
				mem_req.rd_en   = accept && op_ok && list_head_q != NIL;
				mem_req.rd_addr = list_head_q[NODE_W-1:0];
			end
			S_WALK: begin
				mem_req.rd_en   = !key_ge && rd_link != NIL;
				mem_req.rd_addr = rd_link[NODE_W-1:0];
			end
			S_DECIDE: begin
				// Insert fetches the free chain successor; delete unlinks at a predecessor, if any.
				if (op_q == OP_INSERT && !found_q && free_head_q != NIL) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = free_head_q[NODE_W-1:0];
				end else if (op_q == OP_DELETE && found_q && prev_q != NIL) begin
					mem_req.link_we = 1'b1;
					mem_req.wr_addr = prev_q[NODE_W-1:0];
					mem_req.wr_link = nxt_q;
				end
			end
			S_INS_A: begin
				mem_req.key_we  = 1'b1;
				mem_req.link_we = 1'b1;
				mem_req.wr_addr = free_head_q[NODE_W-1:0];
				mem_req.wr_key  = key_q;
				mem_req.wr_link = pos_q;
			end
			S_INS_B: begin
				mem_req.link_we = 1'b1;
				mem_req.wr_addr = prev_q[NODE_W-1:0];
				mem_req.wr_link = LINK_W'(idx_q);
			end
			S_DEL_B: begin
				mem_req.link_we = 1'b1;
				mem_req.wr_addr = pos_q[NODE_W-1:0];
				mem_req.wr_link = free_head_q;
			end
			S_DONE: res_valid = out_free;
			default: ;
		endcase
	end

	assign res_status = status_q;
	assign res_idx    = idx_q;

	// Control state and list heads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			list_head_q <= NIL;
			free_head_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DECIDE && op_q == OP_DELETE && found_q && prev_q == NIL)
				list_head_q <= nxt_q;
			if (state_q == S_INS_A) begin
				free_head_q <= rd_link;
				if (prev_q == NIL)
					list_head_q <= free_head_q;
			end
			if (state_q == S_DEL_B)
				free_head_q <= pos_q;
		end
	end

	// Walk position and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q     <= opcode_t'(req_opcode);
					key_q    <= req_key;
					pos_q    <= list_head_q;
					prev_q   <= NIL;
					found_q  <= 1'b0;
					status_q <= RES_ABSENT;
					idx_q    <= '0;
				end
			end
			S_WALK: begin
				if (key_ge) begin
					found_q <= key_eq;
					nxt_q   <= rd_link;
				end else begin
					prev_q <= pos_q;
					pos_q  <= rd_link;
				end
			end
			S_DECIDE: begin
				status_q <= RES_ABSENT;
				idx_q    <= '0;
				case (op_q)
					OP_SEARCH: begin
						if (found_q) begin
							status_q <= RES_DONE;
							idx_q    <= pos_q[NODE_W-1:0];
						end
					end
					OP_INSERT: begin
						if (found_q)
							status_q <= RES_PRESENT;
						else if (free_head_q == NIL)
							status_q <= RES_NOFREE;
					end
					default: ;
				endcase
			end
			S_INS_A: begin
				status_q <= RES_DONE;
				idx_q    <= free_head_q[NODE_W-1:0];
			end
			S_DEL_B: begin
				status_q <= RES_DONE;
				idx_q    <= pos_q[NODE_W-1:0];
			end
			default: ;
		endcase
	end

	// A result other than done never carries a node index.
	`SSLL_ASSERT_NOW(a_idx_zero, res_valid && status_q != RES_DONE, idx_q == '0)
	// A node is only taken from a non-empty free chain.
	`SSLL_ASSERT_NOW(a_free_taken, state_q == S_INS_A, free_head_q != NIL)
	// The predecessor relink only happens when there is a predecessor.
	`SSLL_ASSERT_NOW(a_prev_link, state_q == S_INS_B, prev_q != NIL)
	// An accepted request always leaves the idle state.
	`SSLL_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE)

endmodule
`default_nettype wire

// ===== tb/ssll_tb_pkg.sv =====
// Scoreboard class for the sorted linked list testbench: its own list model and response queue.
package ssll_tb_pkg;
	import ssll_pkg::*;

	// The block has no name for the fourth opcode; it must be answered as key absent.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		status_t          status;
		logic [IDX_W-1:0] node_index;
	} outcome_t;

	class list_scoreboard;
		key_t     node_key[CAPACITY];
		link_t    node_link[CAPACITY];
		link_t    head;
		link_t    free_top;
		outcome_t outcome_q[$];
		int       errors;

		function new();
			for (int i = 0; i < CAPACITY; i++) begin
				node_key[i] = '0;
				node_link[i] = (i == CAPACITY - 1) ? NIL : LINK_W'(i + 1);
			end
			head = NIL;
			free_top = '0;
			errors = 0;
		endfunction

		// A link that does not name a node ends the chain.
		function link_t next_of(input link_t n);
			link_t v;
			if (n >= NIL)
				return NIL;
			v = node_link[n[NODE_W-1:0]];
			return (v < NIL) ? v : NIL;
		endfunction

		// Work out the response of one accepted request and update the list.
		function void note_request(input logic [1:0] op, input key_t k);
			outcome_t res;
			link_t    pos;
			link_t    prev;
			link_t    node;
			int       steps;
			bit       found;
			res.status = RES_ABSENT;
			res.node_index = '0;
			if (op != OP_UNUSED) begin
				// Walk to the first node whose key is not less than the one asked.
				pos = (head < NIL) ? head : NIL;
				prev = NIL;
				steps = 0;
				while (pos < NIL && steps < CAPACITY) begin
					if (node_key[pos[NODE_W-1:0]] >= k)
						break;
					prev = pos;
					pos = next_of(pos);
					steps++;
				end
				if (steps >= CAPACITY)
					pos = NIL;
				found = (pos < NIL) && (node_key[pos[NODE_W-1:0]] == k);
				case (op)
					OP_SEARCH: begin
						if (found) begin
							res.status = RES_DONE;
							res.node_index = pos[IDX_W-1:0];
						end
					end
					OP_INSERT: begin
						if (found) begin
							res.status = RES_PRESENT;
						end else if (free_top >= NIL) begin
							res.status = RES_NOFREE;
						end else begin
							// Take the head of the free chain and link it in order.
							node = free_top;
							free_top = next_of(node);
							node_key[node[NODE_W-1:0]] = k;
							if (prev >= NIL) begin
								node_link[node[NODE_W-1:0]] = (head < NIL) ? head : NIL;
								head = node;
							end else begin
								node_link[node[NODE_W-1:0]] = next_of(prev);
								node_link[prev[NODE_W-1:0]] = node;
							end
							res.status = RES_DONE;
							res.node_index = node[IDX_W-1:0];
						end
					end
					default: begin
						// Delete unlinks the node and pushes it onto the free chain.
						if (found) begin
							if (prev >= NIL)
								head = next_of(pos);
							else
								node_link[prev[NODE_W-1:0]] = next_of(pos);
							node_link[pos[NODE_W-1:0]] = (free_top < NIL) ? free_top : NIL;
							free_top = pos;
							res.status = RES_DONE;
							res.node_index = pos[IDX_W-1:0];
						end
					end
				endcase
			end
			outcome_q.push_back(res);
		endfunction

		// Compare one accepted response with the oldest expected one.
		function void check_response(input logic [1:0] status, input logic [IDX_W-1:0] idx);
			outcome_t exp;
			if (outcome_q.size() == 0) begin
				errors++;
				$display("%0t: response with no request pending: expected none, actual status %0d index %0d",
					$time, status, idx);
				return;
			end
			exp = outcome_q.pop_front();
			if (status !== exp.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d, actual %0d",
					$time, exp.status, status);
			end
			if (idx !== exp.node_index) begin
				errors++;
				$display("%0t: node_index mismatch: expected %0d, actual %0d",
					$time, exp.node_index, idx);
			end
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		// Pick a random key that is on the list now; returns 0 when the list is empty.
		function bit pick_stored_key(output key_t k);
			key_t  keys[$];
			link_t pos;
			int    steps;
			pos = (head < NIL) ? head : NIL;
			steps = 0;
			k = '0;
			while (pos < NIL && steps < CAPACITY) begin
				keys.push_back(node_key[pos[NODE_W-1:0]]);
				pos = next_of(pos);
				steps++;
			end
			if (keys.size() == 0)
				return 0;
			k = keys[$urandom_range(0, keys.size() - 1)];
			return 1;
		endfunction
	endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench of the sorted linked list: clock, reset, request and response drivers.
module tb_top;
	import ssll_pkg::*;
	import ssll_tb_pkg::*;

	localparam key_t KEY_MIN   = {1'b1, {(KEY_W-1){1'b0}}};
	localparam key_t KEY_MAX   = {1'b0, {(KEY_W-1){1'b1}}};
	localparam int   POOL_SIZE = 128;
	localparam int   HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	bit   idle_on;
	bit   hold_rsp;
	key_t key_pool[POOL_SIZE];

	list_scoreboard sb;

	ssll_req_if req_ch();
	ssll_rsp_if rsp_ch();

	sorted_static_linked_list u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Clock with a period of two time units.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#600000;
		$display("status: fail");
		$finish;
	end

	// Observe both channels at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				sb.note_request(req_ch.opcode, req_ch.key);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.status, rsp_ch.node_index);
		end
	end

	// Response side: random stall bursts, and one long hold-off on demand.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
				rsp_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one request from a falling edge and return at a falling edge once it is taken.
	task automatic send_request(input logic [1:0] op, input key_t k);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.key <= k;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	// Keys lean toward ones on the list, then a fixed pool, then anything.
	function automatic key_t pick_key(input int stored_pct);
		int   r;
		key_t k;
		r = $urandom_range(0, 99);
		if (r < stored_pct && sb.pick_stored_key(k))
			return k;
		if (r < 85)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 95)
			return key_t'($urandom);
		case ($urandom_range(0, 3))
			0: k = KEY_MIN;
			1: k = KEY_MAX;
			2: k = '0;
			default: k = -1;
		endcase
		return k;
	endfunction

	// A run of random requests with given insert and delete shares in percent.
	task automatic run_phase(input int count, input int ins_pct, input int del_pct);
		int         r;
		logic [1:0] op;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				op = OP_UNUSED;
			else if (r < 3 + ins_pct)
				op = OP_INSERT;
			else if (r < 3 + ins_pct + del_pct)
				op = OP_DELETE;
			else
				op = OP_SEARCH;
			send_request(op, pick_key(op == OP_INSERT ? 15 : 55));
		end
	endtask

	// Main sequence: reset, directed requests, random phases, drain and verdict.
	initial begin
		sb = new();
		arst_n = 1'b0;
		idle_on = 1'b1;
		hold_rsp = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_SEARCH;
		req_ch.key = '0;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = key_t'($urandom);
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty list, unused opcode, then keys across the sign boundary and both extremes.
		send_request(OP_SEARCH, '0);
		send_request(OP_DELETE, 32'sd5);
		send_request(OP_UNUSED, KEY_MAX);
		send_request(OP_INSERT, KEY_MIN);
		send_request(OP_INSERT, KEY_MAX);
		send_request(OP_INSERT, '0);
		send_request(OP_INSERT, -1);
		send_request(OP_INSERT, 32'sd1);
		send_request(OP_INSERT, KEY_MAX);
		send_request(OP_SEARCH, KEY_MIN);
		send_request(OP_SEARCH, KEY_MAX);
		send_request(OP_SEARCH, -1);
		send_request(OP_SEARCH, 32'sd2);
		// Delete from the middle, the head and the tail.
		send_request(OP_DELETE, '0);
		send_request(OP_DELETE, KEY_MIN);
		send_request(OP_DELETE, KEY_MAX);
		send_request(OP_SEARCH, '0);
		// Alternating bit patterns reuse freed nodes from the free chain.
		send_request(OP_INSERT, 32'sh5555_5555);
		send_request(OP_INSERT, 32'shAAAA_AAAA);
		send_request(OP_UNUSED, -1);
		send_request(OP_DELETE, -1);
		send_request(OP_DELETE, 32'sd1);
		send_request(OP_DELETE, 32'sh5555_5555);
		send_request(OP_DELETE, 32'shAAAA_AAAA);

		// Fill past capacity so that inserts find no free node.
		run_phase(120, 75, 5);
		// Mixed traffic; the response side holds off so the block fills and stalls.
		hold_rsp = 1'b1;
		run_phase(150, 35, 30);
		// Drain most of the list, then refill.
		run_phase(100, 15, 65);
		run_phase(80, 70, 10);
		// Last part with no idling on either side.
		idle_on = 1'b0;
		run_phase(50, 35, 35);
		req_ch.valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ssll_pkg.sv
rtl/ssll_if.sv
rtl/ssll_store.sv
rtl/ssll_seq.sv
rtl/sorted_static_linked_list.sv
tb/ssll_tb_pkg.sv
tb/tb_top.sv
